[rtl/rwl_pkg.sv]
// Shared types, codes and constants of the reader-writer lock manager.
`default_nettype none
package rwl_pkg;

   localparam int ID_FIELD_W = 8;
   localparam int FUNC_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int READER_CNT_W = 9;
   localparam int WAKE_CNT_W = 5;

   localparam logic [READER_CNT_W-1:0] READER_LIMIT = 9'd511;
   localparam int MAX_WAKE = 16;
   localparam logic [WAKE_CNT_W-1:0] MAX_WAKE_N = 5'd16;

   // Request function codes.
   localparam logic [FUNC_W-1:0] FUNC_RD_LOCK   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RD_UNLOCK = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_WR_LOCK   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_WR_UNLOCK = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_WOKEN    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_MISUSE   = 3'd5;

   typedef enum logic [3:0] {
      OP_RD_LOCK   = 4'b0001,
      OP_RD_UNLOCK = 4'b0010,
      OP_WR_LOCK   = 4'b0100,
      OP_WR_UNLOCK = 4'b1000
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [ID_FIELD_W-1:0] id;
   } cmd_type;

   typedef struct packed {
      logic [ID_FIELD_W-1:0] task_id;
      logic [STATUS_W-1:0]   status;
      logic                  is_reader;
      logic                  last;
   } rsp_type;

   function automatic rsp_type make_rsp(input logic [ID_FIELD_W-1:0] id,
                                        input logic [STATUS_W-1:0] status,
                                        input logic is_reader,
                                        input logic last);
      rsp_type r;
      r.task_id   = id;
      r.status    = status;
      r.is_reader = is_reader;
      r.last      = last;
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/rwl_if.sv]
// Request and response channel interfaces of the lock manager.
`default_nettype none
interface rwl_req_if import rwl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FUNC_W-1:0]     func;
   logic [ID_FIELD_W-1:0] requester_id;

   modport source (output valid, output func, output requester_id, input ready);
   modport sink   (input valid, input func, input requester_id, output ready);
endinterface

interface rwl_rsp_if import rwl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ID_FIELD_W-1:0] task_id;
   logic [STATUS_W-1:0]   status;
   logic                  is_reader;
   logic                  last;

   modport source (output valid, output task_id, output status, output is_reader,
                   output last, input ready);
   modport sink   (input valid, input task_id, input status, input is_reader,
                   input last, output ready);
endinterface
`default_nettype wire

[rtl/reader_writer_lock_manager.sv]
// Path: a single-result request goes through a command slot, then the result register.
// A woken writer, or the first of several woken readers, also goes through a waiter queue
// read register; further woken readers follow one per cycle while rsp_bus.ready allows.
// Throughput: one request per cycle unless the result is stalled, except a release that
// wakes a writer or readers, which holds the back end until its wake results are sent.
// Reset clears the lock state, queue counts and pointers; queue entries are not cleared.
`default_nettype none
module reader_writer_lock_manager import rwl_pkg::*; #(
   parameter int ID_BITS            = 8,
   parameter int READER_QUEUE_DEPTH = 16,
   parameter int WRITER_QUEUE_DEPTH = 16
) (
   input  wire       clock,
   input  wire       reset,
   rwl_req_if.sink   req_bus,
   rwl_rsp_if.source rsp_bus
);

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   rwl_front #(
      .ID_BITS (ID_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   rwl_back #(
      .ID_BITS            (ID_BITS),
      .READER_QUEUE_DEPTH (READER_QUEUE_DEPTH),
      .WRITER_QUEUE_DEPTH (WRITER_QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_bus   (rsp_bus)
   );

endmodule
`default_nettype wire

[rtl/rwl_front.sv]
// Front end: accepts requests, decodes the function and buffers commands.
`default_nettype none
module rwl_front import rwl_pkg::*; #(
   parameter int ID_BITS = 8
) (
   input  wire       clock,
   input  wire       reset,
   rwl_req_if.sink   req_bus,
   output logic      cmd_valid,
   input  wire       cmd_ready,
   output cmd_type   cmd
);

   localparam int KEEP = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
   localparam logic [ID_FIELD_W-1:0] ID_MASK =
      ID_FIELD_W'((ID_FIELD_W+1)'(1) << KEEP) - ID_FIELD_W'(1);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   cmd_type    decoded;

   always_comb begin
      decoded.id = req_bus.requester_id & ID_MASK;
      case (req_bus.func)
         FUNC_RD_LOCK:   decoded.op = OP_RD_LOCK;
         FUNC_RD_UNLOCK: decoded.op = OP_RD_UNLOCK;
         FUNC_WR_LOCK:   decoded.op = OP_WR_LOCK;
         FUNC_WR_UNLOCK: decoded.op = OP_WR_UNLOCK;
         default:        decoded.op = OP_WR_UNLOCK;
      endcase
   end

   assign req_bus.ready = (count_ff != 2'd2);
   assign push      = req_bus.valid && req_bus.ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("command queue count out of range");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("command queue pointers disagree with count");

endmodule
`default_nettype wire

[rtl/rwl_back.sv]
// Back end: lock state, waiter queues and result generation.
`default_nettype none
module rwl_back import rwl_pkg::*; #(
   parameter int ID_BITS            = 8,
   parameter int READER_QUEUE_DEPTH = 16,
   parameter int WRITER_QUEUE_DEPTH = 16
) (
   input  wire       clock,
   input  wire       reset,
   input  wire       cmd_valid,
   output logic      cmd_ready,
   input  cmd_type   cmd,
   rwl_rsp_if.source rsp_bus
);

   localparam int KEEP  = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
   localparam int RQ_AW = (READER_QUEUE_DEPTH > 1) ? $clog2(READER_QUEUE_DEPTH) : 1;
   localparam int RQ_CW = $clog2(READER_QUEUE_DEPTH + 1);
   localparam int WQ_AW = (WRITER_QUEUE_DEPTH > 1) ? $clog2(WRITER_QUEUE_DEPTH) : 1;
   localparam int WQ_CW = $clog2(WRITER_QUEUE_DEPTH + 1);
   localparam logic [RQ_CW-1:0] RQ_FULL  = RQ_CW'(READER_QUEUE_DEPTH);
   localparam logic [RQ_AW-1:0] RQ_LAST  = RQ_AW'(READER_QUEUE_DEPTH - 1);
   localparam logic [RQ_AW:0]   RQ_DEPTH = (RQ_AW+1)'(READER_QUEUE_DEPTH);
   localparam logic [WQ_CW-1:0] WQ_FULL  = WQ_CW'(WRITER_QUEUE_DEPTH);
   localparam logic [WQ_AW-1:0] WQ_LAST  = WQ_AW'(WRITER_QUEUE_DEPTH - 1);
   localparam logic [WQ_AW:0]   WQ_DEPTH = (WQ_AW+1)'(WRITER_QUEUE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE         = 3'b001,
      S_WAKE_WRITER  = 3'b010,
      S_WAKE_READERS = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [READER_CNT_W-1:0] readers_ff, readers_in;
   logic                    writer_holds_ff, writer_holds_in;
   logic [RQ_CW-1:0]        rcount_ff, rcount_in;
   logic [RQ_AW-1:0]        rhead_ff, rhead_in;
   logic [WQ_CW-1:0]        wcount_ff, wcount_in;
   logic [WQ_AW-1:0]        whead_ff, whead_in;
   logic [WAKE_CNT_W-1:0]   wake_left_ff, wake_left_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic [KEEP-1:0] rmem [READER_QUEUE_DEPTH];
   logic [KEEP-1:0] wmem [WRITER_QUEUE_DEPTH];
   logic [KEEP-1:0] rrd_data_ff, wrd_data_ff;
   logic            rwr_en, wwr_en, rrd_en, wrd_en;

   logic [RQ_AW:0]        rtail_sum;
   logic [RQ_AW-1:0]      rtail, rhead_next;
   logic [WQ_AW:0]        wtail_sum;
   logic [WQ_AW-1:0]      wtail, whead_next;
   logic [WAKE_CNT_W-1:0] wake_n;
   logic                  out_free;
   logic                  fire;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign fire     = cmd_valid && cmd_ready;

   // Both queues are circular; the tail is head plus count, wrapped once.
   always_comb begin
      rtail_sum  = {1'b0, rhead_ff} + (RQ_AW+1)'(rcount_ff);
      rtail      = (rtail_sum >= RQ_DEPTH) ? RQ_AW'(rtail_sum - RQ_DEPTH)
                                           : RQ_AW'(rtail_sum);
      rhead_next = (rhead_ff == RQ_LAST) ? '0 : rhead_ff + RQ_AW'(1);
      wtail_sum  = {1'b0, whead_ff} + (WQ_AW+1)'(wcount_ff);
      wtail      = (wtail_sum >= WQ_DEPTH) ? WQ_AW'(wtail_sum - WQ_DEPTH)
                                           : WQ_AW'(wtail_sum);
      whead_next = (whead_ff == WQ_LAST) ? '0 : whead_ff + WQ_AW'(1);
      wake_n     = (32'(rcount_ff) > MAX_WAKE) ? MAX_WAKE_N : WAKE_CNT_W'(rcount_ff);
   end

   always_comb begin
      state_in        = state_ff;
      readers_in      = readers_ff;
      writer_holds_in = writer_holds_ff;
      rcount_in       = rcount_ff;
      rhead_in        = rhead_ff;
      wcount_in       = wcount_ff;
      whead_in        = whead_ff;
      wake_left_in    = wake_left_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in     = rsp_data_ff;
      rwr_en          = 1'b0;
      wwr_en          = 1'b0;
      rrd_en          = 1'b0;
      wrd_en          = 1'b0;
      cmd_ready       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            cmd_ready = out_free;
            if (fire) begin
               rsp_valid_in = 1'b1;
               case (cmd.op)
                  OP_RD_LOCK: begin
                     if (!writer_holds_ff && wcount_ff == '0) begin
                        if (readers_ff == READER_LIMIT) begin
                           rsp_data_in = make_rsp(cmd.id, ST_MISUSE, 1'b1, 1'b1);
                        end else begin
                           readers_in  = readers_ff + READER_CNT_W'(1);
                           rsp_data_in = make_rsp(cmd.id, ST_GRANTED, 1'b1, 1'b1);
                        end
                     end else if (rcount_ff == RQ_FULL) begin
                        rsp_data_in = make_rsp(cmd.id, ST_FULL, 1'b1, 1'b1);
                     end else begin
                        rwr_en      = 1'b1;
                        rcount_in   = rcount_ff + RQ_CW'(1);
                        rsp_data_in = make_rsp(cmd.id, ST_QUEUED, 1'b1, 1'b1);
                     end
                  end
                  OP_RD_UNLOCK: begin
                     if (readers_ff == '0) begin
                        rsp_data_in = make_rsp(cmd.id, ST_MISUSE, 1'b1, 1'b1);
                     end else begin
                        readers_in = readers_ff - READER_CNT_W'(1);
                        if (readers_ff == READER_CNT_W'(1) && wcount_ff != '0) begin
                           // The last reader leaves: hand the lock to the oldest writer.
                           rsp_valid_in    = 1'b0;
                           wrd_en          = 1'b1;
                           whead_in        = whead_next;
                           wcount_in       = wcount_ff - WQ_CW'(1);
                           writer_holds_in = 1'b1;
                           state_in        = S_WAKE_WRITER;
                        end else begin
                           rsp_data_in = make_rsp(cmd.id, ST_RELEASED, 1'b1, 1'b1);
                        end
                     end
                  end
                  OP_WR_LOCK: begin
                     if (!writer_holds_ff && readers_ff == '0) begin
                        writer_holds_in = 1'b1;
                        rsp_data_in     = make_rsp(cmd.id, ST_GRANTED, 1'b0, 1'b1);
                     end else if (wcount_ff == WQ_FULL) begin
                        rsp_data_in = make_rsp(cmd.id, ST_FULL, 1'b0, 1'b1);
                     end else begin
                        wwr_en      = 1'b1;
                        wcount_in   = wcount_ff + WQ_CW'(1);
                        rsp_data_in = make_rsp(cmd.id, ST_QUEUED, 1'b0, 1'b1);
                     end
                  end
                  OP_WR_UNLOCK: begin
                     if (rcount_ff != '0) begin
                        if (({1'b0, readers_ff} + (READER_CNT_W+1)'(wake_n)) >
                            (READER_CNT_W+1)'(READER_LIMIT)) begin
                           rsp_data_in = make_rsp(cmd.id, ST_MISUSE, 1'b0, 1'b1);
                        end else begin
                           // Count is settled now; the head advances as readers drain.
                           rsp_valid_in    = 1'b0;
                           writer_holds_in = 1'b0;
                           readers_in      = readers_ff + READER_CNT_W'(wake_n);
                           rcount_in       = rcount_ff - RQ_CW'(wake_n);
                           wake_left_in    = wake_n;
                           rrd_en          = 1'b1;
                           rhead_in        = rhead_next;
                           state_in        = S_WAKE_READERS;
                        end
                     end else if (wcount_ff != '0) begin
                        rsp_valid_in    = 1'b0;
                        wrd_en          = 1'b1;
                        whead_in        = whead_next;
                        wcount_in       = wcount_ff - WQ_CW'(1);
                        writer_holds_in = 1'b1;
                        state_in        = S_WAKE_WRITER;
                     end else begin
                        writer_holds_in = 1'b0;
                        rsp_data_in     = make_rsp(cmd.id, ST_RELEASED, 1'b0, 1'b1);
                     end
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
                  end
               endcase
            end
         end
         S_WAKE_WRITER: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = make_rsp(ID_FIELD_W'(wrd_data_ff), ST_WOKEN, 1'b0, 1'b1);
               state_in     = S_IDLE;
            end
         end
         S_WAKE_READERS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = make_rsp(ID_FIELD_W'(rrd_data_ff), ST_WOKEN, 1'b1,
                                       wake_left_ff == WAKE_CNT_W'(1));
               wake_left_in = wake_left_ff - WAKE_CNT_W'(1);
               if (wake_left_ff == WAKE_CNT_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  rrd_en   = 1'b1;
                  rhead_in = rhead_next;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         readers_ff      <= '0;
         writer_holds_ff <= 1'b0;
         rcount_ff       <= '0;
         rhead_ff        <= '0;
         wcount_ff       <= '0;
         whead_ff        <= '0;
         wake_left_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         readers_ff      <= readers_in;
         writer_holds_ff <= writer_holds_in;
         rcount_ff       <= rcount_in;
         rhead_ff        <= rhead_in;
         wcount_ff       <= wcount_in;
         whead_ff        <= whead_in;
         wake_left_ff    <= wake_left_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (rwr_en) begin
         rmem[rtail] <= cmd.id[KEEP-1:0];
      end
      if (rrd_en) begin
         rrd_data_ff <= rmem[rhead_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (wwr_en) begin
         wmem[wtail] <= cmd.id[KEEP-1:0];
      end
      if (wrd_en) begin
         wrd_data_ff <= wmem[whead_ff];
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.task_id   = rsp_data_ff.task_id;
   assign rsp_bus.status    = rsp_data_ff.status;
   assign rsp_bus.is_reader = rsp_data_ff.is_reader;
   assign rsp_bus.last      = rsp_data_ff.last;

   a_wake_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAKE_READERS) |-> (wake_left_ff != '0))
      else $error("reader drain with nothing left to wake");

   a_queue_bounds: assert property (@(posedge clock) disable iff (reset)
      (rcount_ff <= RQ_FULL) && (wcount_ff <= WQ_FULL))
      else $error("waiter queue count beyond depth");

   a_cmd_answered: assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_valid_ff || state_ff == S_WAKE_WRITER || state_ff == S_WAKE_READERS))
      else $error("command produced no result and no wake sequence");

   a_writer_woken: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAKE_WRITER) |-> writer_holds_ff)
      else $error("writer woken without holding the lock");

endmodule
`default_nettype wire
